FILE: src/sdse_pkg.sv
// Shared types and constants for the SMTP dot-stuffing / CRLF encoder.
package sdse_pkg;

  typedef logic [7:0] byte_t;

  localparam byte_t CH_LF  = 8'h0A;
  localparam byte_t CH_CR  = 8'h0D;
  localparam byte_t CH_DOT = 8'h2E;

  // Command codes of an input beat.
  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_EOM  = 1'b1
  } cmd_e;

  // Long terminator "\r\n.\r\n"; the short one ".\r\n" is its tail.
  localparam int unsigned TermLen      = 5;
  localparam int unsigned TermShortOfs = 2;
  localparam int unsigned IdxW         = $clog2(TermLen);

  typedef logic [IdxW-1:0] idx_t;

  localparam byte_t TERM_SEQ [TermLen] = '{CH_CR, CH_LF, CH_DOT, CH_CR, CH_LF};

  typedef struct packed {
    cmd_e  command;
    byte_t data_byte;
  } item_t;

  typedef struct packed {
    byte_t out_byte;
    logic  last_of_run;
  } beat_t;

endpackage

FILE: src/sdse_in_if.sv
// Input channel: valid/ready handshake carrying command and data byte.
interface sdse_in_if;
  logic             valid;
  logic             ready;
  logic             command;
  sdse_pkg::byte_t  data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

FILE: src/sdse_out_if.sv
// Output channel: valid/ready handshake carrying encoded byte and run marker.
interface sdse_out_if;
  logic             valid;
  logic             ready;
  sdse_pkg::byte_t  out_byte;
  logic             last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

FILE: src/smtp_dot_stuff_crlf_encoder.sv
// Top level of the SMTP dot-stuffing / LF-to-CRLF encoder.
// Path: an accepted beat passes the input register, then the output register, before
// its first output byte shows, when the sink is ready.
// Throughput: one output byte per cycle while the sink is ready; an input item makes
// 1 or 2 bytes for data, 3 or 5 for end of message, all through the single output port.
// Reset: asynchronous active low; empties both registers, sets stuffing on, previous byte LF.
module smtp_dot_stuff_crlf_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  sdse_in_if.sink    in_i,
  sdse_out_if.source out_o
);

  // Stuffing enable register; the user must write it only while the block is idle (not enforced here).
  logic enable_q, enable_d;

  logic            item_valid;
  sdse_pkg::item_t item;
  sdse_pkg::beat_t gen_beat;
  sdse_pkg::beat_t out_beat;
  logic            take;
  logic            done;

  always_comb begin
    enable_d = enable_q;
    if (cfg_we_i) begin
      enable_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else begin
      enable_q <= enable_d;
    end
  end

  // Hold the input beat until its whole byte run has moved to the output register;
  // accept the next one in the same cycle the last byte leaves.
  sdse_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_data_i    (in_i.data_byte),
    .in_ready_o   (in_i.ready),
    .done_i       (done),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // Pick the byte at the current run position; advance the position on each take,
  // and update the previous body byte only when the run completes.
  sdse_seq_gen u_seq_gen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .enable_i     (enable_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_i       (take),
    .beat_o       (gen_beat),
    .done_o       (done)
  );

  // Output register decouples sink backpressure from the encoder.
  sdse_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .src_valid_i (item_valid),
    .src_beat_i  (gen_beat),
    .take_o      (take),
    .out_valid_o (out_o.valid),
    .out_beat_o  (out_beat),
    .out_ready_i (out_o.ready)
  );

  assign out_o.out_byte    = out_beat.out_byte;
  assign out_o.last_of_run = out_beat.last_of_run;

endmodule

FILE: src/sdse_in_reg.sv
// Input register: holds one accepted item until its last output byte leaves.
module sdse_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_command_i,
  input  sdse_pkg::byte_t   in_data_i,
  output logic              in_ready_o,
  input  logic              done_i,
  output logic              item_valid_o,
  output sdse_pkg::item_t   item_o
);

  logic            valid_q, valid_d;
  sdse_pkg::item_t item_q;
  logic            accept;

  assign in_ready_o = !valid_q || done_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (done_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{command: sdse_pkg::cmd_e'(in_command_i), data_byte: in_data_i};
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

FILE: src/sdse_seq_gen.sv
// Sequence generator: picks the next encoded byte and tracks the previous body byte.
module sdse_seq_gen (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              enable_i,
  input  logic              item_valid_i,
  input  sdse_pkg::item_t   item_i,
  input  logic              take_i,
  output sdse_pkg::beat_t   beat_o,
  output logic              done_o
);

  sdse_pkg::idx_t  idx_q, idx_d;
  sdse_pkg::byte_t prev_q, prev_d;
  sdse_pkg::idx_t  len;
  sdse_pkg::idx_t  term_idx;
  sdse_pkg::byte_t cur_byte;
  logic            prev_lf;
  logic            insert;
  logic            last;
  logic            step;

  assign prev_lf = (prev_q == sdse_pkg::CH_LF);
  assign insert  = enable_i &&
                   (((item_i.data_byte == sdse_pkg::CH_LF) && (prev_q != sdse_pkg::CH_CR)) ||
                    ((item_i.data_byte == sdse_pkg::CH_DOT) && prev_lf));

  always_comb begin
    term_idx = idx_q + (prev_lf ? sdse_pkg::idx_t'(sdse_pkg::TermShortOfs) : '0);
    if (item_i.command == sdse_pkg::CMD_EOM) begin
      len      = prev_lf ? sdse_pkg::idx_t'(sdse_pkg::TermLen - sdse_pkg::TermShortOfs)
                         : sdse_pkg::idx_t'(sdse_pkg::TermLen);
      cur_byte = sdse_pkg::TERM_SEQ[term_idx];
    end else begin
      len = insert ? sdse_pkg::idx_t'(2) : sdse_pkg::idx_t'(1);
      if (insert && (idx_q == '0)) begin
        cur_byte = (item_i.data_byte == sdse_pkg::CH_LF) ? sdse_pkg::CH_CR : sdse_pkg::CH_DOT;
      end else begin
        cur_byte = item_i.data_byte;
      end
    end
  end

  assign last   = (idx_q == len - sdse_pkg::idx_t'(1));
  assign step   = item_valid_i && take_i;
  assign done_o = step && last;
  assign beat_o = '{out_byte: cur_byte, last_of_run: last};

  always_comb begin
    idx_d  = idx_q;
    prev_d = prev_q;
    if (step) begin
      if (last) begin
        idx_d  = '0;
        prev_d = (item_i.command == sdse_pkg::CMD_EOM) ? sdse_pkg::CH_LF : item_i.data_byte;
      end else begin
        idx_d = idx_q + sdse_pkg::idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      prev_q <= sdse_pkg::CH_LF;
    end else begin
      idx_q  <= idx_d;
      prev_q <= prev_d;
    end
  end

endmodule

FILE: src/sdse_out_reg.sv
// Output register: holds one encoded beat until the sink takes it.
module sdse_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              src_valid_i,
  input  sdse_pkg::beat_t   src_beat_i,
  output logic              take_o,
  output logic              out_valid_o,
  output sdse_pkg::beat_t   out_beat_o,
  input  logic              out_ready_i
);

  logic            valid_q, valid_d;
  sdse_pkg::beat_t beat_q;
  logic            load;

  assign load   = !valid_q || out_ready_i;
  assign take_o = src_valid_i && load;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = src_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      beat_q <= src_beat_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;

endmodule

FILE: src/sdse_checker.sv
// Port-level checker for the encoder, bound to the top level.
module sdse_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input sdse_pkg::byte_t out_byte_i,
  input logic            out_last_i
);

  // Stalled beat keeps its valid.
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

  // Stalled beat keeps its payload.
  a_out_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_byte_i) && $stable(out_last_i))
    else $error("output payload changed while stalled");

  // A CR that does not end a run is always followed at once by its LF.
  a_cr_then_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && (out_byte_i == sdse_pkg::CH_CR) && !out_last_i
    |=> out_valid_i && (out_byte_i == sdse_pkg::CH_LF))
    else $error("inner CR not followed by LF");

  // A dot that does not end a run is a stuffed dot or the terminator dot.
  a_dot_then_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && (out_byte_i == sdse_pkg::CH_DOT) && !out_last_i
    |=> out_valid_i && ((out_byte_i == sdse_pkg::CH_DOT) || (out_byte_i == sdse_pkg::CH_CR)))
    else $error("inner dot not followed by dot or CR");

endmodule

bind smtp_dot_stuff_crlf_encoder sdse_checker u_sdse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_last_i  (out_o.last_of_run)
);

FILE: sim/smtp_dot_stuff_crlf_encoder_test.sv
// Self-checking testbench for the SMTP dot-stuffing / LF-to-CRLF encoder.
module smtp_dot_stuff_crlf_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Receiver hold-off for the pressure test, in cycles.
  localparam int unsigned HoldCycles  = 300;
  // Cycles to keep watching after the last expected beat.
  localparam int unsigned DrainCycles = 8;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  sdse_in_if  in_ch ();
  sdse_out_if out_ch ();

  smtp_dot_stuff_crlf_encoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Encoder state as the testbench sees it; matches the block after reset.
  sdse_pkg::byte_t prev_byte  = sdse_pkg::CH_LF;
  logic            stuff_on   = 1'b1;
  sdse_pkg::beat_t expected_beats[$];
  int unsigned     fail_count = 0;

  // Idling controls: burst_mode for the sender and the receiver, hold_out for the receiver.
  bit burst_mode = 1'b0;
  bit hold_out   = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: end the run if the handshakes stop making progress.
  initial begin
    #10_000_000;
    $display("smtp_dot_stuff_crlf_encoder: mismatch");
    $finish;
  end

  function automatic void push_beat(input sdse_pkg::byte_t b, input logic last);
    sdse_pkg::beat_t nb;
    nb.out_byte    = b;
    nb.last_of_run = last;
    expected_beats.push_back(nb);
  endfunction

  // Work out the output bytes of one accepted input beat and advance the state.
  function automatic void encode_item(input sdse_pkg::cmd_e cmd, input sdse_pkg::byte_t data);
    if (cmd == sdse_pkg::CMD_EOM) begin
      // Without a line feed before it the terminator opens a fresh line first.
      if (prev_byte != sdse_pkg::CH_LF) begin
        push_beat(sdse_pkg::CH_CR, 1'b0);
        push_beat(sdse_pkg::CH_LF, 1'b0);
      end
      push_beat(sdse_pkg::CH_DOT, 1'b0);
      push_beat(sdse_pkg::CH_CR, 1'b0);
      push_beat(sdse_pkg::CH_LF, 1'b1);
      prev_byte = sdse_pkg::CH_LF;
    end else begin
      if (stuff_on && data == sdse_pkg::CH_LF && prev_byte != sdse_pkg::CH_CR) begin
        push_beat(sdse_pkg::CH_CR, 1'b0);
      end else if (stuff_on && data == sdse_pkg::CH_DOT && prev_byte == sdse_pkg::CH_LF) begin
        push_beat(sdse_pkg::CH_DOT, 1'b0);
      end
      push_beat(data, 1'b1);
      prev_byte = data;
    end
  endfunction

  // Predict on every accepted input beat.
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      encode_item(sdse_pkg::cmd_e'(in_ch.command), in_ch.data_byte);
    end
  end

  // Compare every accepted output beat with the oldest prediction.
  always @(posedge clk_i) begin : beat_check
    sdse_pkg::beat_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected output beat: out_byte=%h last_of_run=%b",
               out_ch.out_byte, out_ch.last_of_run);
        fail_count++;
      end else begin
        want = expected_beats.pop_front();
        if (out_ch.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, actual %h", want.out_byte, out_ch.out_byte);
          fail_count++;
        end
        if (out_ch.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %b, actual %b", want.last_of_run,
                 out_ch.last_of_run);
          fail_count++;
        end
      end
    end
  end

  // Receiver: stall a random number of cycles before each beat (none in burst mode),
  // or hold off for a long stretch when the pressure test asks for it.
  initial begin : out_sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_out) begin
        stall    = HoldCycles;
        hold_out = 1'b0;
      end else begin
        stall = burst_mode ? 0 : $urandom_range(0, 14);
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // Offer one input beat after a random gap (none in burst mode) and hold it until accepted.
  // Valid stays high on return; the next call or idle_input settles it.
  task automatic send_item(input sdse_pkg::cmd_e cmd, input sdse_pkg::byte_t data);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_ch.valid     <= 1'b0;
      in_ch.data_byte <= sdse_pkg::byte_t'($urandom_range(0, 255));
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.data_byte <= data;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic idle_input();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    idle_input();
    while (expected_beats.size() != 0) @(posedge clk_i);
  endtask

  // Write the stuffing enable once the block has delivered everything.
  task automatic write_stuffing(input logic enable);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= enable;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    stuff_on     = enable;
  endtask

  // Body bytes weighted toward the characters that steer the encoder.
  function automatic sdse_pkg::byte_t pick_byte();
    sdse_pkg::byte_t b;
    case ($urandom_range(0, 9))
      0, 1:    b = sdse_pkg::CH_LF;
      2:       b = sdse_pkg::CH_CR;
      3, 4:    b = sdse_pkg::CH_DOT;
      5, 6, 7: b = sdse_pkg::byte_t'(8'h61 + $urandom_range(0, 25));
      default: b = sdse_pkg::byte_t'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // Send a message of random text, closed by an end-of-message beat.
  task automatic send_message(output int unsigned n_sent);
    int unsigned len;
    len = $urandom_range(0, 20);
    for (int unsigned i = 0; i < len; i++) begin
      send_item(sdse_pkg::CMD_DATA, pick_byte());
    end
    send_item(sdse_pkg::CMD_EOM, sdse_pkg::byte_t'($urandom_range(0, 255)));
    n_sent = len + 1;
  endtask

  // Hand-picked beats: both terminators, inserted CR, doubled dot,
  // pass-through and a mode change in the middle of a message.
  task automatic test_directed();
    send_item(sdse_pkg::CMD_EOM, 8'h00);            // empty message: short terminator
    send_item(sdse_pkg::CMD_DATA, sdse_pkg::CH_DOT); // dot at start of message: doubled
    send_item(sdse_pkg::CMD_DATA, 8'h41);
    send_item(sdse_pkg::CMD_DATA, sdse_pkg::CH_LF);  // bare LF: CR inserted
    send_item(sdse_pkg::CMD_DATA, sdse_pkg::CH_CR);
    send_item(sdse_pkg::CMD_DATA, sdse_pkg::CH_LF);  // LF after CR: unchanged
    send_item(sdse_pkg::CMD_DATA, sdse_pkg::CH_DOT); // dot at line start: doubled
    send_item(sdse_pkg::CMD_DATA, sdse_pkg::CH_DOT); // dot after dot: unchanged
    send_item(sdse_pkg::CMD_DATA, 8'h00);
    send_item(sdse_pkg::CMD_DATA, 8'hFF);
    send_item(sdse_pkg::CMD_EOM, 8'hFF);            // last byte not LF: long terminator
    send_item(sdse_pkg::CMD_DATA, sdse_pkg::CH_LF);  // line feed remembered after terminator
    send_item(sdse_pkg::CMD_DATA, sdse_pkg::CH_LF);
    send_item(sdse_pkg::CMD_EOM, 8'h00);
    write_stuffing(1'b0);
    send_item(sdse_pkg::CMD_DATA, sdse_pkg::CH_LF);  // pass-through: no CR
    send_item(sdse_pkg::CMD_DATA, sdse_pkg::CH_DOT); // pass-through: no doubling
    send_item(sdse_pkg::CMD_DATA, 8'h78);
    send_item(sdse_pkg::CMD_EOM, 8'h55);
    send_item(sdse_pkg::CMD_DATA, sdse_pkg::CH_DOT);
    send_item(sdse_pkg::CMD_DATA, sdse_pkg::CH_LF);
    write_stuffing(1'b1);                           // mode change mid-message, LF remembered
    send_item(sdse_pkg::CMD_DATA, sdse_pkg::CH_DOT);
    send_item(sdse_pkg::CMD_DATA, sdse_pkg::CH_CR);
    send_item(sdse_pkg::CMD_EOM, 8'hAA);
    send_item(sdse_pkg::CMD_EOM, 8'h80);
  endtask

  // Random messages over alternating modes, with some stray beats and
  // a couple of phases without idling.
  task automatic test_random_messages();
    int unsigned sent;
    int unsigned n;
    for (int unsigned phase = 0; phase < 8; phase++) begin
      write_stuffing((phase % 2 == 0) ? 1'b1 : 1'b0);
      burst_mode = (phase == 2) || (phase == 5);
      sent = 0;
      while (sent < 52) begin
        if ($urandom_range(0, 7) == 0) begin
          // Drop in a stray beat outside the usual message shape.
          send_item($urandom_range(0, 1) ? sdse_pkg::CMD_EOM : sdse_pkg::CMD_DATA,
                    sdse_pkg::byte_t'($urandom_range(0, 255)));
          sent++;
        end else begin
          send_message(n);
          sent += n;
        end
      end
    end
    burst_mode = 1'b0;
  endtask

  // Hold the receiver off while the sender keeps offering beats back to
  // back, so the block fills up and stalls its input.
  task automatic test_backpressure();
    write_stuffing(1'b1);
    burst_mode = 1'b1;
    hold_out   = 1'b1;
    for (int unsigned i = 0; i < 40; i++) begin
      if (i % 9 == 8) send_item(sdse_pkg::CMD_EOM, sdse_pkg::byte_t'($urandom_range(0, 255)));
      else            send_item(sdse_pkg::CMD_DATA, pick_byte());
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.command   <= sdse_pkg::CMD_DATA;
    in_ch.data_byte <= 8'h00;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= 1'b0;
    rst_ni          <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_messages();
    test_backpressure();

    // Let the last beats out, then watch a little longer for stray ones.
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("smtp_dot_stuff_crlf_encoder: match");
    end else begin
      $display("smtp_dot_stuff_crlf_encoder: mismatch");
    end
    $finish;
  end

endmodule
